// ----- rtl/cau_pkg.sv -----
// Package with the widths, codes, types and helper functions of the complex arithmetic unit.
package cau_pkg;

    localparam int DW = 32;
    localparam int FB = 16;
    localparam int PW = 2 * DW;
    localparam int SW = 2 * DW + 1;
    localparam int QB = DW + 1;
    localparam int NW = SW + FB;
    localparam int CW = NW + QB;

    typedef enum logic [2:0] {
        MODE_ADD = 3'd0,
        MODE_SUB = 3'd1,
        MODE_MUL = 3'd2,
        MODE_DIV = 3'd3,
        MODE_CMP = 3'd4
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_DIVZ = 2'd1,
        ST_OVF  = 2'd2
    } t_status;

    typedef struct packed {
        t_mode          mode;
        logic           eq;
        logic [DW-1:0]  res_re;
        logic [DW-1:0]  res_im;
        t_status        status;
    } t_side;

    typedef struct packed {
        logic [SW-1:0]  den;
        logic [NW-1:0]  rem_re;
        logic [NW-1:0]  rem_im;
        logic [QB-1:0]  q_re;
        logic [QB-1:0]  q_im;
        logic           ov_re;
        logic           ov_im;
        logic           neg_re;
        logic           neg_im;
        t_side          side;
    } t_div_stage;

    // Clamps a sign and magnitude to DW bits; the top bit of the result is the overflow flag.
    function automatic logic [DW:0] sat_mag(input logic neg, input logic [NW-1:0] mag);
        logic [NW-1:0] lim;
        logic [NW-1:0] m;
        logic          ovf;
        lim = (NW'(1) << (DW - 1)) - NW'(!neg);
        m   = mag;
        ovf = 1'b0;
        if (mag > lim) begin
            m   = lim;
            ovf = 1'b1;
        end
        return {ovf, (neg ? (DW'(0) - m[DW-1:0]) : m[DW-1:0])};
    endfunction

    // One restoring division step at quotient bit position pos; the top bit is the quotient bit.
    function automatic logic [NW:0] div_step(input logic [NW-1:0] rem, input logic [SW-1:0] den,
                                             input int pos);
        logic [CW-1:0] dsh;
        logic [CW-1:0] rw;
        logic          bit_q;
        dsh   = CW'(den) << pos;
        rw    = CW'(rem);
        bit_q = (rw >= dsh);
        if (bit_q) begin
            rw = rw - dsh;
        end
        return {bit_q, rw[NW-1:0]};
    endfunction

endpackage

// ----- rtl/cau_op_if.sv -----
// Interface for the operand word channel.
interface cau_op_if;
    import cau_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [2:0]           mode;
    logic signed [DW-1:0] a_re;
    logic signed [DW-1:0] a_im;
    logic signed [DW-1:0] b_re;
    logic signed [DW-1:0] b_im;
    modport source (output valid, mode, a_re, a_im, b_re, b_im, input ready);
    modport sink   (input valid, mode, a_re, a_im, b_re, b_im, output ready);
endinterface

// ----- rtl/cau_res_if.sv -----
// Interface for the result word channel.
interface cau_res_if;
    import cau_pkg::*;
    logic                 valid;
    logic                 ready;
    logic signed [DW-1:0] res_re;
    logic signed [DW-1:0] res_im;
    logic                 equal;
    logic [1:0]           status;
    modport source (output valid, res_re, res_im, equal, status, input ready);
    modport sink   (input valid, res_re, res_im, equal, status, output ready);
endinterface

// ----- rtl/cau_divider.sv -----
// Pipelined restoring divider, one quotient bit per stage for both result parts.
module cau_divider (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  cau_pkg::t_div_stage i_data,
    output logic                o_valid,
    output cau_pkg::t_div_stage o_data
);
    import cau_pkg::*;

    logic       r_vld [QB+1];
    t_div_stage r_st  [QB+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_st[0] <= i_data;
        end
    end

    for (genvar k = 0; k < QB; k++) begin : g_step
        t_div_stage n_st;
        logic [NW:0] s_re;
        logic [NW:0] s_im;

        always_comb begin
            s_re = div_step(r_st[k].rem_re, r_st[k].den, QB - 1 - k);
            s_im = div_step(r_st[k].rem_im, r_st[k].den, QB - 1 - k);
            n_st = r_st[k];
            n_st.rem_re = s_re[NW-1:0];
            n_st.rem_im = s_im[NW-1:0];
            n_st.q_re[QB-1-k] = s_re[NW];
            n_st.q_im[QB-1-k] = s_im[NW];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[k+1] <= r_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_st[k+1] <= n_st;
            end
        end
    end

    assign o_valid = r_vld[QB];
    assign o_data  = r_st[QB];

endmodule

// ----- rtl/complex_arithmetic_unit.sv -----
// Complex arithmetic unit top: sum, multiply, divide and compare pipeline with output skid.
//
//  channel  dir  payload                          meaning
//  i_op     in   mode, a_re, a_im, b_re, b_im     operand word
//  o_res    out  res_re, res_im, equal, status    result word
//
// One word enters per cycle while the skid register is empty. Each word passes r1, r2, the
// restoring divider (one pipeline stage on each of its 33 quotient bits) and then r_out.
// Synchronous reset clears all valid bits; the data path registers are not reset.
// When o_res stalls, the waiting word moves to a skid register and the whole pipeline
// holds until it is taken, so no word is lost or repeated.
module complex_arithmetic_unit (
    input  logic      i_clk,
    input  logic      i_rst_n,
    cau_op_if.sink    i_op,
    cau_res_if.source o_res
);
    import cau_pkg::*;

    logic en;

    logic                 r1_vld;
    t_side                r1_side;
    logic signed [PW-1:0] r1_prr, r1_pii, r1_pri, r1_pir, r1_pbr, r1_pbi;
    t_side                n1_side;
    logic signed [DW:0]   s_re1, s_im1;
    logic [DW:0]          m_re1, m_im1;
    logic [DW:0]          sat_re1, sat_im1;

    logic                 r2_vld;
    t_side                r2_side;
    logic signed [SW-1:0] r2_mre, r2_mim, r2_dre, r2_dim;
    logic [SW-1:0]        r2_den;

    t_div_stage           n_div;
    logic [SW-1:0]        m_re3, m_im3;
    logic [DW:0]          sat_re3, sat_im3;
    logic [NW-1:0]        num_re, num_im;

    logic                 div_vld;
    t_div_stage           div_out;
    t_side                n_out;
    logic [DW:0]          sat_qre, sat_qim;

    logic                 r_out_vld, r_skid_vld;
    t_side                r_out, r_skid;

    assign en = !r_skid_vld;
    assign i_op.ready = en;

    always_comb begin
        n1_side      = '0;
        n1_side.mode = t_mode'(i_op.mode);
        n1_side.eq   = (t_mode'(i_op.mode) == MODE_CMP) && (i_op.a_re == i_op.b_re)
                       && (i_op.a_im == i_op.b_im);
        if (t_mode'(i_op.mode) == MODE_SUB) begin
            s_re1 = (DW+1)'(i_op.a_re) - (DW+1)'(i_op.b_re);
            s_im1 = (DW+1)'(i_op.a_im) - (DW+1)'(i_op.b_im);
        end else begin
            s_re1 = (DW+1)'(i_op.a_re) + (DW+1)'(i_op.b_re);
            s_im1 = (DW+1)'(i_op.a_im) + (DW+1)'(i_op.b_im);
        end
        m_re1   = s_re1[DW] ? ((DW+1)'(0) - s_re1) : s_re1;
        m_im1   = s_im1[DW] ? ((DW+1)'(0) - s_im1) : s_im1;
        sat_re1 = sat_mag(s_re1[DW], NW'(m_re1));
        sat_im1 = sat_mag(s_im1[DW], NW'(m_im1));
        if (t_mode'(i_op.mode) == MODE_ADD || t_mode'(i_op.mode) == MODE_SUB) begin
            n1_side.res_re = sat_re1[DW-1:0];
            n1_side.res_im = sat_im1[DW-1:0];
            n1_side.status = (sat_re1[DW] || sat_im1[DW]) ? ST_OVF : ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
        end else if (en) begin
            r1_vld <= i_op.valid;
            r2_vld <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_side <= n1_side;
            r1_prr  <= PW'(i_op.a_re) * PW'(i_op.b_re);
            r1_pii  <= PW'(i_op.a_im) * PW'(i_op.b_im);
            r1_pri  <= PW'(i_op.a_re) * PW'(i_op.b_im);
            r1_pir  <= PW'(i_op.a_im) * PW'(i_op.b_re);
            r1_pbr  <= PW'(i_op.b_re) * PW'(i_op.b_re);
            r1_pbi  <= PW'(i_op.b_im) * PW'(i_op.b_im);
            r2_side <= r1_side;
            r2_mre  <= SW'(r1_prr) - SW'(r1_pii);
            r2_mim  <= SW'(r1_pri) + SW'(r1_pir);
            r2_dre  <= SW'(r1_prr) + SW'(r1_pii);
            r2_dim  <= SW'(r1_pir) - SW'(r1_pri);
            r2_den  <= SW'(r1_pbr) + SW'(r1_pbi);
        end
    end

    always_comb begin
        m_re3   = r2_mre[SW-1] ? (SW'(0) - r2_mre) : r2_mre;
        m_im3   = r2_mim[SW-1] ? (SW'(0) - r2_mim) : r2_mim;
        sat_re3 = sat_mag(r2_mre[SW-1], NW'(m_re3 >> FB));
        sat_im3 = sat_mag(r2_mim[SW-1], NW'(m_im3 >> FB));
        num_re  = NW'(r2_dre[SW-1] ? (SW'(0) - r2_dre) : r2_dre) << FB;
        num_im  = NW'(r2_dim[SW-1] ? (SW'(0) - r2_dim) : r2_dim) << FB;

        n_div        = '0;
        n_div.den    = r2_den;
        n_div.rem_re = num_re;
        n_div.rem_im = num_im;
        n_div.neg_re = r2_dre[SW-1];
        n_div.neg_im = r2_dim[SW-1];
        n_div.ov_re  = CW'(num_re) >= (CW'(r2_den) << QB);
        n_div.ov_im  = CW'(num_im) >= (CW'(r2_den) << QB);
        n_div.side   = r2_side;
        case (r2_side.mode)
            MODE_MUL: begin
                n_div.side.res_re = sat_re3[DW-1:0];
                n_div.side.res_im = sat_im3[DW-1:0];
                n_div.side.status = (sat_re3[DW] || sat_im3[DW]) ? ST_OVF : ST_OK;
            end
            MODE_DIV: begin
                n_div.side.status = (r2_den == '0) ? ST_DIVZ : ST_OK;
            end
            default: begin
            end
        endcase
    end

    cau_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r2_vld),
        .i_data  (n_div),
        .o_valid (div_vld),
        .o_data  (div_out)
    );

    always_comb begin
        sat_qre = sat_mag(div_out.neg_re,
                          div_out.ov_re ? {NW{1'b1}} : NW'(div_out.q_re));
        sat_qim = sat_mag(div_out.neg_im,
                          div_out.ov_im ? {NW{1'b1}} : NW'(div_out.q_im));
        n_out = div_out.side;
        if (div_out.side.mode == MODE_DIV && div_out.side.status != ST_DIVZ) begin
            n_out.res_re = sat_qre[DW-1:0];
            n_out.res_im = sat_qim[DW-1:0];
            n_out.status = (sat_qre[DW] || sat_qim[DW]) ? ST_OVF : ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (r_skid_vld) begin
            if (o_res.ready) begin
                r_skid_vld <= 1'b0;
            end
        end else begin
            r_skid_vld <= r_out_vld && !o_res.ready;
            r_out_vld  <= div_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_skid <= r_out;
            r_out  <= n_out;
        end
    end

    assign o_res.valid  = r_skid_vld || r_out_vld;
    assign o_res.res_re = r_skid_vld ? r_skid.res_re : r_out.res_re;
    assign o_res.res_im = r_skid_vld ? r_skid.res_im : r_out.res_im;
    assign o_res.equal  = r_skid_vld ? r_skid.eq : r_out.eq;
    assign o_res.status = r_skid_vld ? r_skid.status : r_out.status;

endmodule

// ----- sim/tb_complex_arithmetic_unit.sv -----
// Testbench for the complex arithmetic unit: random and directed operands checked against a predictor.
module tb_complex_arithmetic_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import cau_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 60;

    typedef struct packed {
        logic [DW-1:0] re;
        logic [DW-1:0] im;
        logic          eq;
        logic [1:0]    st;
    } t_expect;

    logic i_clk;
    logic i_rst_n;
    cau_op_if  op_ch ();
    cau_res_if res_ch ();

    complex_arithmetic_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_op    (op_ch.sink),
        .o_res   (res_ch.source)
    );

    t_expect expected_results[$];
    int      mismatches;
    int      results_seen;
    int      words_sent;
    int      idle_pct;
    int      stall_pct;
    int      quiet_cycles;

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    function automatic logic [DW-1:0] clamp(input logic signed [191:0] v, inout logic ovf);
        logic signed [191:0] hi;
        logic signed [191:0] lo;
        hi = (192'sd1 <<< (DW - 1)) - 1;
        lo = -(192'sd1 <<< (DW - 1));
        if (v > hi) begin
            ovf = 1'b1;
            return hi[DW-1:0];
        end
        if (v < lo) begin
            ovf = 1'b1;
            return lo[DW-1:0];
        end
        return v[DW-1:0];
    endfunction

    // Truncating shift and division on signed values, rounding toward zero.
    function automatic logic signed [191:0] shr_trunc(input logic signed [191:0] v);
        logic signed [191:0] m;
        m = (v < 0) ? -v : v;
        m = m >>> FB;
        return (v < 0) ? -m : m;
    endfunction

    function automatic logic signed [191:0] div_trunc(input logic signed [191:0] n,
                                                      input logic signed [191:0] d);
        logic signed [191:0] m;
        m = (n < 0) ? -n : n;
        m = (m <<< FB) / d;
        return (n < 0) ? -m : m;
    endfunction

    function automatic t_expect compute_complex(input logic [2:0] mode,
            input logic signed [DW-1:0] ar, input logic signed [DW-1:0] ai,
            input logic signed [DW-1:0] br, input logic signed [DW-1:0] bi);
        t_expect             r;
        logic                ovf;
        logic signed [191:0] xr, xi, yr, yi, den;
        r   = '0;
        ovf = 1'b0;
        xr  = ar;
        xi  = ai;
        yr  = br;
        yi  = bi;
        case (mode)
            MODE_ADD: begin
                r.re = clamp(xr + yr, ovf);
                r.im = clamp(xi + yi, ovf);
            end
            MODE_SUB: begin
                r.re = clamp(xr - yr, ovf);
                r.im = clamp(xi - yi, ovf);
            end
            MODE_MUL: begin
                r.re = clamp(shr_trunc(xr * yr - xi * yi), ovf);
                r.im = clamp(shr_trunc(xr * yi + xi * yr), ovf);
            end
            MODE_DIV: begin
                den = yr * yr + yi * yi;
                if (den == 0) begin
                    r.st = ST_DIVZ;
                end else begin
                    r.re = clamp(div_trunc(xr * yr + xi * yi, den), ovf);
                    r.im = clamp(div_trunc(xi * yr - xr * yi, den), ovf);
                end
            end
            MODE_CMP: r.eq = (ar == br) && (ai == bi);
            default: ;
        endcase
        if (ovf) begin
            r.st = ST_OVF;
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [DW-1:0] got,
                                   input logic [DW-1:0] want);
        $display("Mismatch in %s of result %0d: got %h, expected %h",
                 what, results_seen, got, want);
        mismatches++;
    endtask

    task automatic send_operands(input logic [2:0] mode, input logic [DW-1:0] ar,
            input logic [DW-1:0] ai, input logic [DW-1:0] br, input logic [DW-1:0] bi);
        while ($urandom_range(99) < idle_pct) begin
            op_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        op_ch.valid <= 1'b1;
        op_ch.mode  <= mode;
        op_ch.a_re  <= ar;
        op_ch.a_im  <= ai;
        op_ch.b_re  <= br;
        op_ch.b_im  <= bi;
        @(posedge i_clk);
        while (!op_ch.ready) begin
            @(posedge i_clk);
        end
        expected_results.push_back(compute_complex(mode, ar, ai, br, bi));
        words_sent++;
    endtask

    always @(posedge i_clk) begin
        res_ch.ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        t_expect want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            results_seen++;
            if (expected_results.size() == 0) begin
                $display("Unexpected result word %0d", results_seen);
                mismatches++;
            end else begin
                want = expected_results.pop_front();
                if (res_ch.res_re !== want.re) report_mismatch("res_re", res_ch.res_re, want.re);
                if (res_ch.res_im !== want.im) report_mismatch("res_im", res_ch.res_im, want.im);
                if (res_ch.equal !== want.eq) begin
                    report_mismatch("equal", DW'(res_ch.equal), DW'(want.eq));
                end
                if (res_ch.status !== want.st) begin
                    report_mismatch("status", DW'(res_ch.status), DW'(want.st));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((op_ch.valid && op_ch.ready) || (res_ch.valid && res_ch.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles > WATCHDOG_LIMIT) begin
            $display("Timeout with %0d results outstanding", expected_results.size());
            $display("FAILURE");
            $finish;
        end
    end

    function automatic logic [DW-1:0] rand_value();
        case ($urandom_range(5))
            0: return $urandom;
            1: return DW'($urandom_range(8)) - 4;
            2: return {1'b0, {(DW - 1){1'b1}}} - $urandom_range(3);
            3: return {1'b1, {(DW - 1){1'b0}}} + $urandom_range(3);
            4: return DW'(signed'($urandom_range(1 << 21)) - (1 << 20));
            default: return DW'(signed'($urandom_range(1 << 25)) - (1 << 24));
        endcase
    endfunction

    task automatic test_directed();
        logic [DW-1:0] mx, mn;
        mx = {1'b0, {(DW - 1){1'b1}}};
        mn = {1'b1, {(DW - 1){1'b0}}};
        send_operands(MODE_ADD, mx, mn, 1, '1);
        send_operands(MODE_ADD, mn, mx, mn, mx);
        send_operands(MODE_SUB, mn, mx, 1, '1);
        send_operands(MODE_SUB, 0, 0, mn, mn);
        send_operands(MODE_MUL, 32'h0001_0000, 0, 32'h0002_8000, 0);
        send_operands(MODE_MUL, mn, mn, mn, mn);
        send_operands(MODE_MUL, mx, mx, mx, mn);
        send_operands(MODE_MUL, '1, 1, 1, '1);
        send_operands(MODE_DIV, 32'h0003_0000, 0, 0, 0);
        send_operands(MODE_DIV, 32'h0003_0000, 32'h0001_0000, 32'h0002_0000, 0);
        send_operands(MODE_DIV, mx, mx, 1, 0);
        send_operands(MODE_DIV, mn, mn, mn, mn);
        send_operands(MODE_DIV, 0, 0, 0, 0);
        send_operands(MODE_DIV, '1, 0, 32'h0003_0000, 32'h0001_0000);
        send_operands(MODE_CMP, mn, mx, mn, mx);
        send_operands(MODE_CMP, mn, mx, mn, mn);
        send_operands(MODE_CMP, 5, 7, 7, 7);
        send_operands(3'd5, mx, mx, mx, mx);
        send_operands(3'd6, 1, 2, 3, 4);
        send_operands(3'd7, mn, 0, mn, 0);
    endtask

    task automatic test_random(input int count);
        logic [2:0]    mode;
        logic [DW-1:0] ar, ai, br, bi;
        repeat (count) begin
            mode = ($urandom_range(19) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(4));
            ar = rand_value();
            ai = ($urandom_range(4) == 0) ? '0 : rand_value();
            br = rand_value();
            bi = ($urandom_range(4) == 0) ? '0 : rand_value();
            if (mode == MODE_CMP && $urandom_range(1)) begin
                br = ar;
                bi = $urandom_range(1) ? ai : ai ^ (DW'(1) << $urandom_range(DW - 1));
            end
            send_operands(mode, ar, ai, br, bi);
        end
    endtask

    task automatic run_phase(input int idle, input int stall, input int count);
        idle_pct  = idle;
        stall_pct = stall;
        test_random(count);
    endtask

    initial begin
        i_rst_n      = 1'b0;
        op_ch.valid  = 1'b0;
        op_ch.mode   = '0;
        op_ch.a_re   = '0;
        op_ch.a_im   = '0;
        op_ch.b_re   = '0;
        op_ch.b_im   = '0;
        res_ch.ready = 1'b1;
        mismatches   = 0;
        results_seen = 0;
        words_sent   = 0;
        idle_pct     = 0;
        stall_pct    = 0;
        quiet_cycles = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        run_phase(0, 0, 300);
        run_phase(75, 0, 250);
        run_phase(0, 75, 250);
        run_phase(15, 15, 280);
        op_ch.valid <= 1'b0;
        stall_pct = 0;
        while (expected_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Sent %0d operand words over all modes and idling phases.", words_sent);
        $display("Checked %0d result words, %0d mismatches.", results_seen, mismatches);
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
